[design/mqttd_pkg.sv]
// Shared types and constants for the MQTT packet deframer.
package mqttd_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 28;
  localparam int GROUP_W = 7;
  localparam int CNT_W   = 2;
  localparam int CONT_BIT = 7;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Framing phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Byte role codes
  localparam logic [1:0] ROLE_HEADER = 2'd0;
  localparam logic [1:0] ROLE_LENGTH = 2'd1;
  localparam logic [1:0] ROLE_BODY   = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_OVERSIZE  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [1:0]        byte_role;
    logic [BYTE_W-1:0] header_value;
    logic [LEN_W-1:0]  length_value;
    logic              length_done;
    logic              last_of_packet;
    logic [1:0]        error_code;
  } res_t;

endpackage

[design/mqttd_in_if.sv]
// Input channel interface: one received byte per transaction.
interface mqttd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/mqttd_out_if.sv]
// Result channel interface: one tagged byte per transaction.
interface mqttd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [1:0]  byte_role;
  logic [7:0]  header_value;
  logic [27:0] length_value;
  logic        length_done;
  logic        last_of_packet;
  logic [1:0]  error_code;

  modport source (output valid, output data_byte, output byte_role, output header_value,
                  output length_value, output length_done, output last_of_packet,
                  output error_code, input ready);
  modport sink   (input valid, input data_byte, input byte_role, input header_value,
                  input length_value, input length_done, input last_of_packet,
                  input error_code, output ready);
endinterface

[design/mqtt_packet_deframer_unit.sv]
// Top level of the MQTT packet deframer: config register, framer and result register.
//
// Usage:
//   rx  - input channel, one received stream byte per transaction (rx_byte).
//   res - result channel, one transaction per byte taken: the byte itself, its role
//         (header, remaining-length or body), the packet header, the decoded remaining
//         length, a length-complete flag, a last-of-packet mark and an error code.
//   cfg_we / cfg_wdata - write the maximum remaining length; write only while idle.
// A byte taken at an edge is loaded into the result register and appears on res after that edge.
// Throughput is one byte per cycle while the receiver keeps res ready; the framer's phase,
// length accumulator and body counter are all updated when the result register is loaded.
// Reset holds rx not ready, returns the framer to expecting a header byte, empties the
// result register and sets the maximum remaining length to its largest value.
// When the receiver stalls, the result register holds its transaction and rx stays
// ready only if that register is being emptied in the same cycle; nothing is lost.
// A length field still continuing on its last permitted byte is flagged malformed and
// ends the packet; a length above the maximum is flagged oversize and the body still
// passes through.
module mqtt_packet_deframer_unit #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  mqttd_in_if.sink                     rx,
  mqttd_out_if.source                  res,
  input  logic                         cfg_we,
  input  logic [mqttd_pkg::LEN_W-1:0]  cfg_wdata
);
  import mqttd_pkg::*;

  logic [LEN_W-1:0] max_len;
  logic             accept;
  logic             out_valid;
  res_t             step_res;
  res_t             out_q;

  // Take a new byte out of reset whenever the result register is empty or being drained.
  assign rx.ready = !rst && (!out_valid || res.ready);
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= LEN_MAX;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  mqttd_framer #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_framer (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .rx_byte (rx.rx_byte),
    .max_len (max_len),
    .result  (step_res)
  );

  // Result register: load on every taken byte, hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= step_res;
    end
  end

  assign res.valid          = out_valid;
  assign res.data_byte      = out_q.data_byte;
  assign res.byte_role      = out_q.byte_role;
  assign res.header_value   = out_q.header_value;
  assign res.length_value   = out_q.length_value;
  assign res.length_done    = out_q.length_done;
  assign res.last_of_packet = out_q.last_of_packet;
  assign res.error_code     = out_q.error_code;

  // A header byte carries itself as header and nothing decoded yet.
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.byte_role == ROLE_HEADER) |->
      (out_q.header_value == out_q.data_byte && !out_q.length_done &&
       !out_q.last_of_packet && out_q.error_code == ERR_NONE))
    else $error("header byte result not clean");

  // Length reads zero until the field is complete.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_q.length_done) |-> (out_q.length_value == '0))
    else $error("length reported before field complete");

  // A malformed length field always ends the packet on a length byte.
  a_malformed_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_q.error_code == ERR_MALFORMED) |->
      (out_q.last_of_packet && out_q.byte_role == ROLE_LENGTH))
    else $error("malformed length not closing packet");

  // The byte after a packet's last byte is a header.
  a_header_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && res.ready && out_q.last_of_packet) |=>
      (out_q.byte_role == ROLE_HEADER))
    else $error("packet end not followed by header");

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

[design/mqttd_framer.sv]
// Framing state machine: classifies each byte and decodes the remaining length.
module mqttd_framer #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [mqttd_pkg::BYTE_W-1:0]        rx_byte,
  input  logic [mqttd_pkg::LEN_W-1:0]         max_len,
  output mqttd_pkg::res_t                     result
);
  import mqttd_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LENGTH_BYTES - 1);

  logic [1:0]        phase, phase_next;
  logic [BYTE_W-1:0] held_header, held_header_next;
  logic [LEN_W-1:0]  acc, acc_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [LEN_W-1:0]  left, left_next;
  logic              oversize, oversize_next;

  logic [4:0]        shamt;
  logic [LEN_W-1:0]  acc_or;
  logic [LEN_W-1:0]  left_dec;
  logic              over_max;

  always_comb begin
    unique case (cnt)
      2'd0:    shamt = 5'd0;
      2'd1:    shamt = 5'd7;
      2'd2:    shamt = 5'd14;
      default: shamt = 5'd21;
    endcase
  end

  assign acc_or   = acc | (LEN_W'(rx_byte[GROUP_W-1:0]) << shamt);
  assign over_max = acc_or > max_len;
  assign left_dec = left - LEN_W'(1);

  always_comb begin
    phase_next       = phase;
    held_header_next = held_header;
    acc_next         = acc;
    cnt_next         = cnt;
    left_next        = left;
    oversize_next    = oversize;

    result.data_byte      = rx_byte;
    result.byte_role      = ROLE_HEADER;
    result.header_value   = held_header;
    result.length_value   = '0;
    result.length_done    = 1'b0;
    result.last_of_packet = 1'b0;
    result.error_code     = ERR_NONE;

    unique case (phase)
      PH_LENGTH: begin
        result.byte_role = ROLE_LENGTH;
        acc_next         = acc_or;
        cnt_next         = cnt + CNT_W'(1);
        if (rx_byte[CONT_BIT]) begin
          if (cnt == CNT_LAST) begin
            // overlong field: drop the packet, restart on the next byte
            phase_next            = PH_HEADER;
            result.last_of_packet = 1'b1;
            result.error_code     = ERR_MALFORMED;
          end
        end else begin
          oversize_next      = over_max;
          result.length_done = 1'b1;
          result.error_code  = over_max ? ERR_OVERSIZE : ERR_NONE;
          if (acc_or == '0) begin
            phase_next            = PH_HEADER;
            result.last_of_packet = 1'b1;
          end else begin
            phase_next          = PH_BODY;
            left_next           = acc_or;
            result.length_value = acc_or;
          end
        end
      end
      PH_BODY: begin
        left_next             = left_dec;
        result.byte_role      = ROLE_BODY;
        result.length_value   = acc;
        result.length_done    = 1'b1;
        result.last_of_packet = (left_dec == '0);
        result.error_code     = oversize ? ERR_OVERSIZE : ERR_NONE;
        if (left_dec == '0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        held_header_next    = rx_byte;
        acc_next            = '0;
        cnt_next            = '0;
        left_next           = '0;
        oversize_next       = 1'b0;
        phase_next          = PH_LENGTH;
        result.header_value = rx_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_header <= held_header_next;
      acc         <= acc_next;
      cnt         <= cnt_next;
      left        <= left_next;
      oversize    <= oversize_next;
    end
  end

endmodule

[tb/sv/tb.sv]
// Testbench for the MQTT packet deframer: directed byte table, then random packet traffic.
`timescale 1ns / 100ps

module tb;
  import mqttd_pkg::*;

  // Length field may span at most this many bytes (the block's default parameter)
  localparam int FIELD_BYTES     = 4;
  // Cycles with no transaction on either channel before the run is abandoned
  localparam int WATCHDOG_CYCLES = 2000;
  // Random traffic: eight phases, each ending with the first packet that passes this many bytes
  localparam int PHASE_BYTES     = 140;

  localparam res_t NO_RES = '0;

  // One row of the directed table: a register write or a byte, with an optional
  // hand-written expectation that overrides the predictor for that byte
  typedef struct packed {
    logic             is_cfg;
    logic             pinned;
    logic [LEN_W-1:0] val;
    res_t             r;
  } step_row_t;

  typedef struct packed {
    logic pinned;
    res_t r;
  } pin_t;

  // Directed part under the reset maximum, then with the maximum lowered to 3:
  // zero-length packet, all-ones header, overlong length field, a padded
  // four-byte length of 1, an oversize packet and a packet exactly at the maximum.
  localparam step_row_t DIR_TAB [25] = '{
    '{1'b0, 1'b1, 28'h30, '{8'h30, ROLE_HEADER, 8'h30, 28'd0, 1'b0, 1'b0, ERR_NONE}},
    '{1'b0, 1'b1, 28'h00, '{8'h00, ROLE_LENGTH, 8'h30, 28'd0, 1'b1, 1'b1, ERR_NONE}},
    '{1'b0, 1'b1, 28'hFF, '{8'hFF, ROLE_HEADER, 8'hFF, 28'd0, 1'b0, 1'b0, ERR_NONE}},
    '{1'b0, 1'b0, 28'hFF, NO_RES},
    '{1'b0, 1'b0, 28'hFF, NO_RES},
    '{1'b0, 1'b0, 28'hFF, NO_RES},
    '{1'b0, 1'b1, 28'hFF, '{8'hFF, ROLE_LENGTH, 8'hFF, 28'd0, 1'b0, 1'b1, ERR_MALFORMED}},
    '{1'b0, 1'b1, 28'h00, '{8'h00, ROLE_HEADER, 8'h00, 28'd0, 1'b0, 1'b0, ERR_NONE}},
    '{1'b0, 1'b0, 28'h81, NO_RES},
    '{1'b0, 1'b0, 28'h80, NO_RES},
    '{1'b0, 1'b0, 28'h80, NO_RES},
    '{1'b0, 1'b1, 28'h00, '{8'h00, ROLE_LENGTH, 8'h00, 28'd1, 1'b1, 1'b0, ERR_NONE}},
    '{1'b0, 1'b1, 28'hA5, '{8'hA5, ROLE_BODY, 8'h00, 28'd1, 1'b1, 1'b1, ERR_NONE}},
    '{1'b1, 1'b0, 28'd3,  NO_RES},
    '{1'b0, 1'b0, 28'h82, NO_RES},
    '{1'b0, 1'b1, 28'h04, '{8'h04, ROLE_LENGTH, 8'h82, 28'd4, 1'b1, 1'b0, ERR_OVERSIZE}},
    '{1'b0, 1'b0, 28'h00, NO_RES},
    '{1'b0, 1'b0, 28'hFF, NO_RES},
    '{1'b0, 1'b0, 28'h55, NO_RES},
    '{1'b0, 1'b1, 28'hAA, '{8'hAA, ROLE_BODY, 8'h82, 28'd4, 1'b1, 1'b1, ERR_OVERSIZE}},
    '{1'b0, 1'b0, 28'h10, NO_RES},
    '{1'b0, 1'b1, 28'h03, '{8'h03, ROLE_LENGTH, 8'h10, 28'd3, 1'b1, 1'b0, ERR_NONE}},
    '{1'b0, 1'b0, 28'h5A, NO_RES},
    '{1'b0, 1'b0, 28'hC3, NO_RES},
    '{1'b0, 1'b1, 28'h3C, '{8'h3C, ROLE_BODY, 8'h10, 28'd3, 1'b1, 1'b1, ERR_NONE}}
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  mqttd_in_if  in_ch ();
  mqttd_out_if res_ch ();

  mqtt_packet_deframer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .rx        (in_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: a private copy of the framer and of the maximum length register
  logic [1:0]       fr_phase;
  logic [7:0]       fr_hdr;
  logic [LEN_W-1:0] fr_acc;
  logic [2:0]       fr_cnt;
  logic [LEN_W-1:0] fr_left;
  logic             fr_over;
  logic [LEN_W-1:0] max_len;

  pin_t pinned_q [$];   // per byte in flight: hand-written expectation, if any
  res_t tagged_q [$];   // tagged bytes still owed by the block, oldest first

  int send_idle_pct;
  int recv_stall_pct;
  int sent_cnt;
  int fail_cnt;
  int quiet_cyc = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the tagged result for one byte and advance the framer copy
  function automatic res_t deframe_byte(input logic [7:0] b);
    res_t             o;
    logic [LEN_W-1:0] grp;
    logic [2:0]       n;
    o = '0;
    o.data_byte = b;
    case (fr_phase)
      PH_LENGTH: begin
        // Merge the next 7-bit group, least significant group first
        grp = {21'd0, b[GROUP_W-1:0]} << (7 * fr_cnt[1:0]);
        fr_acc = fr_acc | grp;
        n = fr_cnt + 3'd1;
        fr_cnt = n;
        o.byte_role = ROLE_LENGTH;
        o.header_value = fr_hdr;
        if (b[CONT_BIT]) begin
          // Still continuing on the last permitted byte: malformed, packet ends here
          if (n >= FIELD_BYTES) begin
            fr_phase = PH_HEADER;
            o.last_of_packet = 1'b1;
            o.error_code = ERR_MALFORMED;
          end
        end else begin
          fr_over = (fr_acc > max_len);
          o.error_code = fr_over ? ERR_OVERSIZE : ERR_NONE;
          o.length_done = 1'b1;
          if (fr_acc == '0) begin
            fr_phase = PH_HEADER;
            o.last_of_packet = 1'b1;
          end else begin
            fr_left = fr_acc;
            fr_phase = PH_BODY;
            o.length_value = fr_acc;
          end
        end
      end
      PH_BODY: begin
        fr_left = fr_left - LEN_W'(1);
        o.byte_role = ROLE_BODY;
        o.header_value = fr_hdr;
        o.length_value = fr_acc;
        o.length_done = 1'b1;
        o.last_of_packet = (fr_left == '0);
        o.error_code = fr_over ? ERR_OVERSIZE : ERR_NONE;
        if (fr_left == '0) fr_phase = PH_HEADER;
      end
      default: begin
        // Header byte; the unused phase code lands here too
        fr_hdr = b;
        fr_acc = '0;
        fr_cnt = '0;
        fr_left = '0;
        fr_over = 1'b0;
        fr_phase = PH_LENGTH;
        o.byte_role = ROLE_HEADER;
        o.header_value = b;
      end
    endcase
    return o;
  endfunction

  task automatic chk_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Offer one byte: idle at random first, then hold valid until the transaction
  // goes through. Entered and left at a falling edge.
  task automatic put_byte(input logic [7:0] b, input logic pin, input res_t r);
    pin_t pe;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pe.pinned = pin;
    pe.r = r;
    pinned_q.push_back(pe);
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_cnt++;
    @(negedge clk);
  endtask

  // Drain every outstanding result, then write the maximum length register.
  // Every byte yields a result, so an empty store means the block is idle.
  task automatic set_max(input logic [LEN_W-1:0] v);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tagged_q.size() != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    max_len = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: drop ready at random according to the current stall rate
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Input side: predict each accepted byte; a pinned row replaces the prediction
  always @(posedge clk) begin
    pin_t pe;
    res_t guess;
    if (!rst && in_ch.valid && in_ch.ready) begin
      guess = deframe_byte(in_ch.rx_byte);
      if (pinned_q.size() != 0) begin
        pe = pinned_q.pop_front();
        if (pe.pinned) guess = pe.r;
      end
      tagged_q.push_back(guess);
    end
  end

  // Result side: compare each transaction field by field with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.data_byte, res_ch.byte_role, res_ch.header_value, res_ch.length_value,
             res_ch.length_done, res_ch.last_of_packet, res_ch.error_code};
      if (tagged_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("%0t: result with nothing expected: byte %0h role %0d",
                   $realtime, got.data_byte, got.byte_role);
      end else begin
        want = tagged_q.pop_front();
        chk_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
        chk_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
        chk_field("header_value", 32'(want.header_value), 32'(got.header_value));
        chk_field("length_value", 32'(want.length_value), 32'(got.length_value));
        chk_field("length_done", 32'(want.length_done), 32'(got.length_done));
        chk_field("last_of_packet", 32'(want.last_of_packet), 32'(got.last_of_packet));
        chk_field("error_code", 32'(want.error_code), 32'(got.error_code));
      end
    end
  end

  // Watchdog: abandon the run if neither channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WATCHDOG_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    step_row_t        row;
    logic [LEN_W-1:0] cap;
    logic [6:0]       grp;
    int               ph;
    int               base;
    int               kind;
    int               len;
    int               nlen;
    int               pad;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sent_cnt = 0;
    fail_cnt = 0;
    // Predictor starts from the block's reset state
    fr_phase = PH_HEADER;
    fr_hdr = '0;
    fr_acc = '0;
    fr_cnt = '0;
    fr_left = '0;
    fr_over = 1'b0;
    max_len = LEN_MAX;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table, no idling on either side
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      row = DIR_TAB[i];
      if (row.is_cfg)
        set_max(row.val);
      else
        put_byte(row.val[7:0], row.pinned, row.r);
    end

    // Random packets: each phase picks a maximum length and an idling pattern
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       cap = LEN_MAX;
        1:       cap = '0;
        2:       cap = LEN_W'($urandom_range(1, 30));
        3:       cap = LEN_W'(127);
        4:       cap = LEN_W'($urandom_range(0, 32'h0FFF_FFFF));
        5:       cap = LEN_W'(1);
        6:       cap = LEN_W'($urandom_range(10, 200));
        default: cap = LEN_MAX;
      endcase
      set_max(cap);
      send_idle_pct  = (ph % 4 == 1) ? 66 : (ph % 4 == 3) ? 35 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 66 : (ph % 4 == 3) ? 35 : 0;
      base = sent_cnt;
      while (sent_cnt - base < PHASE_BYTES) begin
        kind = $urandom_range(99);
        put_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        if (kind < 8) begin
          // Broken packet: length field that never ends within the permitted bytes
          repeat (FIELD_BYTES) put_byte(8'h80 | 8'($urandom_range(127)), 1'b0, NO_RES);
        end else begin
          // Well-formed packet; sometimes pad the length with zero groups
          len  = (kind < 18) ? 0 : (kind < 88) ? $urandom_range(1, 24) : $urandom_range(25, 300);
          nlen = (len < 128) ? 1 : 2;
          pad  = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
          if (nlen + pad > FIELD_BYTES) pad = FIELD_BYTES - nlen;
          for (int k = 0; k < nlen + pad; k++) begin
            grp = 7'(len >> (7 * k));
            put_byte({(k < nlen + pad - 1), grp}, 1'b0, NO_RES);
          end
          repeat (len) put_byte(8'($urandom_range(255)), 1'b0, NO_RES);
        end
      end
    end

    // Drain the outstanding results before the verdict
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (tagged_q.size() != 0);
    repeat (4) @(negedge clk);
    if (fail_cnt == 0 && tagged_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
